[hw/rtl/vsbt_pkg.sv]
package vsbt_pkg;

    typedef enum logic [1:0] {
        FUNC_LOAD          = 2'd0,
        FUNC_START         = 2'd1,
        FUNC_SEND_OUTCOME  = 2'd2,
        FUNC_REPLY_OUTCOME = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ACT_NONE = 3'd0,
        ACT_SEND = 3'd1,
        ACT_READ = 3'd2,
        ACT_DONE = 3'd3,
        ACT_FAIL = 3'd4
    } action_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_ADDRESS       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_STATUS           = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SEND_RETRY_LIMIT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLY_RETRY_LIMIT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MISMATCH_RETRY_LIMIT = 3'd4;

    localparam logic [6:0] RST_TARGET_ADDRESS       = 7'd0;
    localparam logic [7:0] RST_ACK_STATUS           = 8'hAA;
    localparam logic [3:0] RST_SEND_RETRY_LIMIT     = 4'd3;
    localparam logic [3:0] RST_REPLY_RETRY_LIMIT    = 4'd2;
    localparam logic [3:0] RST_MISMATCH_RETRY_LIMIT = 4'd2;

    // reflected CRC-8/MAXIM polynomial
    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

    typedef struct packed {
        func_t      func;
        logic [7:0] data_byte;
        logic [6:0] length;
        logic [7:0] start_seq;
        logic       bus_ok;
        logic [7:0] reply_status;
        logic [7:0] reply_seq;
        logic [7:0] reply_data;
    } req_t;

    typedef struct packed {
        action_t    action;
        logic [6:0] cmd_address;
        logic [7:0] cmd_seq;
        logic [7:0] cmd_data;
        logic [7:0] packet_crc;
    } rsp_t;

    typedef struct packed {
        logic [6:0] target_address;
        logic [7:0] ack_status;
        logic [3:0] send_retry_limit;
        logic [3:0] reply_retry_limit;
        logic [3:0] mismatch_retry_limit;
    } cfg_t;

    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hw/rtl/vsbt_cfg_regs.sv]
module vsbt_cfg_regs
    import vsbt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_address       <= RST_TARGET_ADDRESS;
            cfg_reg.ack_status           <= RST_ACK_STATUS;
            cfg_reg.send_retry_limit     <= RST_SEND_RETRY_LIMIT;
            cfg_reg.reply_retry_limit    <= RST_REPLY_RETRY_LIMIT;
            cfg_reg.mismatch_retry_limit <= RST_MISMATCH_RETRY_LIMIT;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_TARGET_ADDRESS:       cfg_reg.target_address       <= wr_data[6:0];
                REG_ACK_STATUS:           cfg_reg.ack_status           <= wr_data;
                REG_SEND_RETRY_LIMIT:     cfg_reg.send_retry_limit     <= wr_data[3:0];
                REG_REPLY_RETRY_LIMIT:    cfg_reg.reply_retry_limit    <= wr_data[3:0];
                REG_MISMATCH_RETRY_LIMIT: cfg_reg.mismatch_retry_limit <= wr_data[3:0];
                default:                  ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/vsbt_pkt_buf.sv]
module vsbt_pkt_buf
    import vsbt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/vsbt_ctrl.sv]
module vsbt_ctrl
    import vsbt_pkg::*;
#(
    parameter int MAX_BYTES = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic go,
    input  req_t item,
    input  cfg_t cfg,
    output rsp_t result
);

    localparam int CW = $clog2(MAX_BYTES + 1);
    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEND,
        PH_REPLY
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [CW-1:0] load_ptr_reg, load_ptr_next;
    logic [7:0]    crc_reg, crc_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] tlen_reg, tlen_next;
    logic [7:0]    first_seq_reg, first_seq_next;
    logic [3:0]    send_cnt_reg, send_cnt_next;
    logic [3:0]    reply_cnt_reg, reply_cnt_next;
    logic [3:0]    mis_cnt_reg, mis_cnt_next;
    // prefetched bytes at byte_index and byte_index + 1
    logic [7:0]    cur_data_reg, cur_data_next;
    logic [7:0]    nxt_data_reg, nxt_data_next;

    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    logic [7:0]    cur_seq;
    logic [CW:0]   idx_inc;
    logic [CW+1:0] ahead;
    logic [CW-1:0] len_eff;
    logic          echo_ok;

    vsbt_pkt_buf #(
        .DEPTH (MAX_BYTES),
        .AW    (AW)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (load_ptr_reg[AW-1:0]),
        .wr_data (item.data_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cur_seq = 8'(idx_reg) + first_seq_reg;
    assign idx_inc = {1'b0, idx_reg} + 1'b1;
    assign ahead   = (CW + 2)'(idx_inc) + (CW + 2)'(2);
    assign len_eff = (8'(item.length) > 8'(load_ptr_reg)) ? load_ptr_reg : CW'(item.length);
    assign echo_ok = (item.reply_status == cfg.ack_status) && (item.reply_seq == cur_seq)
                     && (item.reply_data == cur_data_reg);

    always_comb
    begin
        phase_next     = phase_reg;
        load_ptr_next  = load_ptr_reg;
        crc_next       = crc_reg;
        idx_next       = idx_reg;
        tlen_next      = tlen_reg;
        first_seq_next = first_seq_reg;
        send_cnt_next  = send_cnt_reg;
        reply_cnt_next = reply_cnt_reg;
        mis_cnt_next   = mis_cnt_reg;
        cur_data_next  = cur_data_reg;
        nxt_data_next  = nxt_data_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        result         = '0;
        result.action  = ACT_NONE;

        unique case (item.func)
            FUNC_LOAD:
            begin
                if (phase_reg == PH_IDLE && load_ptr_reg < CW'(MAX_BYTES))
                begin
                    wr_en         = go;
                    load_ptr_next = load_ptr_reg + 1'b1;
                    crc_next      = crc8_fold(crc_reg, item.data_byte);
                    if (load_ptr_reg == '0)
                    begin
                        cur_data_next = item.data_byte;
                    end
                    if (load_ptr_reg == CW'(1))
                    begin
                        nxt_data_next = item.data_byte;
                    end
                end
            end
            FUNC_START:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    tlen_next      = len_eff;
                    first_seq_next = item.start_seq;
                    idx_next       = '0;
                    send_cnt_next  = '0;
                    reply_cnt_next = '0;
                    mis_cnt_next   = '0;
                    if (len_eff == '0)
                    begin
                        phase_next        = PH_IDLE;
                        load_ptr_next     = '0;
                        crc_next          = '0;
                        result.action     = ACT_DONE;
                        result.packet_crc = crc_reg;
                    end
                    else
                    begin
                        phase_next         = PH_SEND;
                        result.action      = ACT_SEND;
                        result.cmd_address = cfg.target_address;
                        result.cmd_seq     = item.start_seq;
                        result.cmd_data    = cur_data_reg;
                        if (MAX_BYTES > 2)
                        begin
                            rd_en   = go;
                            rd_addr = AW'(2);
                        end
                    end
                end
            end
            FUNC_SEND_OUTCOME:
            begin
                if (phase_reg == PH_SEND)
                begin
                    if (item.bus_ok)
                    begin
                        send_cnt_next      = '0;
                        phase_next         = PH_REPLY;
                        result.action      = ACT_READ;
                        result.cmd_address = cfg.target_address;
                    end
                    else if (send_cnt_reg < cfg.send_retry_limit)
                    begin
                        send_cnt_next      = send_cnt_reg + 1'b1;
                        result.action      = ACT_SEND;
                        result.cmd_address = cfg.target_address;
                        result.cmd_seq     = cur_seq;
                        result.cmd_data    = cur_data_reg;
                    end
                    else
                    begin
                        phase_next    = PH_IDLE;
                        load_ptr_next = '0;
                        crc_next      = '0;
                        result.action = ACT_FAIL;
                    end
                end
            end
            FUNC_REPLY_OUTCOME:
            begin
                if (phase_reg == PH_REPLY)
                begin
                    if (!item.bus_ok)
                    begin
                        if (reply_cnt_reg < cfg.reply_retry_limit)
                        begin
                            reply_cnt_next     = reply_cnt_reg + 1'b1;
                            phase_next         = PH_SEND;
                            result.action      = ACT_SEND;
                            result.cmd_address = cfg.target_address;
                            result.cmd_seq     = cur_seq;
                            result.cmd_data    = cur_data_reg;
                        end
                        else
                        begin
                            phase_next    = PH_IDLE;
                            load_ptr_next = '0;
                            crc_next      = '0;
                            result.action = ACT_FAIL;
                        end
                    end
                    else
                    begin
                        reply_cnt_next = '0;
                        if (echo_ok)
                        begin
                            idx_next = idx_inc[CW-1:0];
                            if (idx_inc >= {1'b0, tlen_reg})
                            begin
                                phase_next        = PH_IDLE;
                                load_ptr_next     = '0;
                                crc_next          = '0;
                                result.action     = ACT_DONE;
                                result.packet_crc = crc_reg;
                            end
                            else
                            begin
                                // advance: slide the prefetch window, fetch two ahead
                                phase_next         = PH_SEND;
                                cur_data_next      = nxt_data_reg;
                                nxt_data_next      = rd_data;
                                result.action      = ACT_SEND;
                                result.cmd_address = cfg.target_address;
                                result.cmd_seq     = cur_seq + 8'd1;
                                result.cmd_data    = nxt_data_reg;
                                if (ahead < (CW + 2)'(MAX_BYTES))
                                begin
                                    rd_en   = go;
                                    rd_addr = ahead[AW-1:0];
                                end
                            end
                        end
                        else if (mis_cnt_reg < cfg.mismatch_retry_limit)
                        begin
                            mis_cnt_next       = mis_cnt_reg + 1'b1;
                            phase_next         = PH_SEND;
                            result.action      = ACT_SEND;
                            result.cmd_address = cfg.target_address;
                            result.cmd_seq     = cur_seq;
                            result.cmd_data    = cur_data_reg;
                        end
                        else
                        begin
                            phase_next    = PH_IDLE;
                            load_ptr_next = '0;
                            crc_next      = '0;
                            result.action = ACT_FAIL;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            load_ptr_reg  <= '0;
            crc_reg       <= '0;
            idx_reg       <= '0;
            tlen_reg      <= '0;
            first_seq_reg <= '0;
            send_cnt_reg  <= '0;
            reply_cnt_reg <= '0;
            mis_cnt_reg   <= '0;
            cur_data_reg  <= '0;
            nxt_data_reg  <= '0;
        end
        else if (go)
        begin
            phase_reg     <= phase_next;
            load_ptr_reg  <= load_ptr_next;
            crc_reg       <= crc_next;
            idx_reg       <= idx_next;
            tlen_reg      <= tlen_next;
            first_seq_reg <= first_seq_next;
            send_cnt_reg  <= send_cnt_next;
            reply_cnt_reg <= reply_cnt_next;
            mis_cnt_reg   <= mis_cnt_next;
            cur_data_reg  <= cur_data_next;
            nxt_data_reg  <= nxt_data_next;
        end
    end

endmodule

[hw/rtl/verified_sequenced_byte_transfer.sv]
// Verified sequenced byte transfer, CRC-8/MAXIM over the loaded packet.
//
// req channel (req_valid / req_stall / req): one item per transaction. func selects
// load byte, start transfer, send outcome or reply outcome. rsp channel (rsp_valid /
// rsp_stall / rsp): exactly one result per accepted item, in order: the next bus
// action (send data command, read 3-byte reply, done ok with packet_crc, failed, none).
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register writes, always
// ready; write only while the block is idle.
//
// An accepted item is registered in the input register, evaluated, and its result is
// registered in the result register and presented from then on. Throughput is one
// item per cycle while rsp_stall is low, set by the single evaluation stage between
// the input and result registers; the packet buffer is a one-write, one-read memory
// with a two-byte prefetch window so the current and next byte are always at hand.
//
// Reset clears all control state and loads the register defaults; no clearing pass.
// When rsp_stall holds, the result register keeps its transaction, one further item
// is held in the input register, and req_stall rises until the result is taken.
module verified_sequenced_byte_transfer
    import vsbt_pkg::*;
#(
    parameter int MAX_BYTES = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  req_t                   req,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output rsp_t                   rsp,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg;
    req_t req_reg;
    logic req_valid_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic rsp_valid_reg;
    logic out_open;
    logic go;
    logic accept;

    assign cfg_ready = 1'b1;
    assign out_open  = !rsp_valid_reg || !rsp_stall;
    assign go        = req_valid_reg && out_open;
    assign req_stall = req_valid_reg && !out_open;
    assign accept    = req_valid && !req_stall;

    vsbt_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    vsbt_ctrl #(
        .MAX_BYTES (MAX_BYTES)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .item   (req_reg),
        .cfg    (cfg),
        .result (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                req_valid_reg <= 1'b1;
            end
            else if (go)
            begin
                req_valid_reg <= 1'b0;
            end

            if (go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (go)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[hw/rtl/vsbt_checker.sv]
module vsbt_checker
    import vsbt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // a stalled result transaction stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("rsp changed or dropped while stalled");

    // input backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("req_stall without a stalled result");

    // an accepted transaction reaches the result register when the output is open
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
        else $error("result missing after accepted transaction");

    // command fields are zero unless a bus action is issued
    a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.action == ACT_NONE || rsp.action == ACT_DONE
                      || rsp.action == ACT_FAIL)
        |-> rsp.cmd_address == '0 && rsp.cmd_seq == '0 && rsp.cmd_data == '0)
        else $error("command fields set on a non-bus result");

    // crc is reported only with a successful end
    a_crc_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.action != ACT_DONE |-> rsp.packet_crc == '0)
        else $error("packet_crc set outside done ok");

endmodule

bind verified_sequenced_byte_transfer vsbt_checker u_vsbt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
